[rtl/core/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, request and status codes and sizes for the positional list
// engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    // list capacity and derived widths
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int FLD_W   = 5;
    localparam int CMP_W   = (CNT_W > FLD_W) ? CNT_W : FLD_W;

    // request codes
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_DELETE = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_FIND   = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // request word
    typedef struct packed {
        logic [2:0]         req_type;
        logic [FLD_W-1:0]   position;
        logic signed [31:0] data_value;
    } req_t;

    // response word
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [FLD_W-1:0]   found_index;
        logic [FLD_W-1:0]   entry_count;
    } rsp_t;

    // per-cell load select
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } cell_ctl_t;

    // chain-wide shift command
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [IDX_W-1:0] pos;
    } chain_ctl_t;

endpackage

[rtl/core/positional_list_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values addressed by index: insert, delete,
// read, find and clear, one response word per request word.
// ----------------------------------------------------------------------------
// Usage:
//   req/req_valid/req_stall carry request words (type, position, value);
//   rsp/rsp_valid/rsp_stall carry response words (status, read value,
//   found index or removed count, entry count after the request).
//   A word moves on a rising edge with valid high and stall low.
//   Each request is served in the cycle it is accepted: the row of cells
//   shifts, compares and selects all entries at once, and the response sits
//   in the output register in the cycle after. One request per cycle is taken
//   as long as the response side keeps up; the rate is set by the single
//   output register, which is refilled in the same cycle it is drained.
//   While a response waits under rsp_stall, req_stall is raised and no new
//   request is taken; the held response does not change.
//   Reset empties the list (count zero) and drops any pending response;
//   cell contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ple_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ple_pkg::rsp_t   rsp
);

    logic [ple_pkg::CNT_W-1:0] count_reg;
    logic [ple_pkg::CNT_W-1:0] count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    ple_pkg::rsp_t             rsp_reg;
    ple_pkg::rsp_t             rsp_next;

    logic                      accept;
    logic [ple_pkg::CMP_W-1:0] pos_ext;
    logic [ple_pkg::CMP_W-1:0] cnt_ext;
    logic [ple_pkg::CMP_W-1:0] fidx;
    logic                      full;
    ple_pkg::chain_ctl_t       cctl;
    logic signed [31:0]        rd_value;
    logic                      hit;
    logic [ple_pkg::IDX_W-1:0] hit_idx;

    // handshake
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign pos_ext = ple_pkg::CMP_W'(req.position);
    assign cnt_ext = ple_pkg::CMP_W'(count_reg);
    assign full    = (count_reg == ple_pkg::CNT_W'(ple_pkg::ENTRIES));

    // request decode and response build
    always_comb
    begin
        count_next          = count_reg;
        cctl.ins            = 1'b0;
        cctl.del            = 1'b0;
        cctl.pos            = pos_ext[ple_pkg::IDX_W-1:0];
        fidx                = '0;
        rsp_next.status     = ple_pkg::ST_OK;
        rsp_next.read_value = '0;
        case (req.req_type)
            ple_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ple_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    rsp_next.status = ple_pkg::ST_MISS;
                end
                else
                begin
                    cctl.ins   = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ple_pkg::REQ_DELETE:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_next.status = ple_pkg::ST_MISS;
                end
                else
                begin
                    cctl.del   = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            ple_pkg::REQ_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    rsp_next.status = ple_pkg::ST_MISS;
                end
                else
                begin
                    rsp_next.read_value = rd_value;
                end
            end
            ple_pkg::REQ_FIND:
            begin
                if (hit)
                begin
                    fidx = ple_pkg::CMP_W'(hit_idx);
                end
                else
                begin
                    rsp_next.status = ple_pkg::ST_MISS;
                end
            end
            ple_pkg::REQ_CLEAR:
            begin
                fidx       = cnt_ext;
                count_next = '0;
            end
            default:
            begin
                rsp_next.status = ple_pkg::ST_MISS;
            end
        endcase
        rsp_next.found_index = fidx[ple_pkg::FLD_W-1:0];
        rsp_next.entry_count = ple_pkg::CMP_W'(count_next) & ple_pkg::CMP_W'(5'h1f);
    end

    // cell row
    ple_chain u_chain (
        .clk       (clk),
        .ctl       (cctl),
        .new_value (req.data_value),
        .count     (count_reg),
        .rd_value  (rd_value),
        .hit       (hit),
        .hit_idx   (hit_idx)
    );

    // output valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // response word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // count never exceeds capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::CNT_W'(ple_pkg::ENTRIES))
        else $error("entry count above capacity");

    // a full status only comes from a full list
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (rsp_next.status == ple_pkg::ST_FULL) |-> full)
        else $error("list full reported with free entries");

    // a successful insert grows the list by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.req_type == ple_pkg::REQ_INSERT)
            && (rsp_next.status == ple_pkg::ST_OK)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

    // response register is held while a request is stalled
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |=> rsp_valid_reg && (rsp_reg == $past(rsp_reg)))
        else $error("pending response lost under stall");

endmodule

[rtl/core/ple_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list entry: holds a value, loads a new one or a neighbor's, and
// compares against the search key.
// ----------------------------------------------------------------------------
module ple_cell (
    input  logic                clk,
    input  ple_pkg::cell_ctl_t  ctl,
    input  logic signed [31:0]  new_value,
    input  logic signed [31:0]  left_value,
    input  logic signed [31:0]  right_value,
    input  logic signed [31:0]  key,
    output logic signed [31:0]  value,
    output logic                match
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // pick next entry value
    always_comb
    begin
        value_next = value_reg;
        if (ctl.load_new)
        begin
            value_next = new_value;
        end
        else if (ctl.take_left)
        begin
            value_next = left_value;
        end
        else if (ctl.take_right)
        begin
            value_next = right_value;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == key);

endmodule

[rtl/core/ple_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_chain
// Row of list cells with per-cell shift control, indexed read and a
// first-match search over the occupied entries.
// ----------------------------------------------------------------------------
module ple_chain (
    input  logic                          clk,
    input  ple_pkg::chain_ctl_t           ctl,
    input  logic signed [31:0]            new_value,
    input  logic [ple_pkg::CNT_W-1:0]     count,
    output logic signed [31:0]            rd_value,
    output logic                          hit,
    output logic [ple_pkg::IDX_W-1:0]     hit_idx
);

    logic signed [31:0] vals [ple_pkg::ENTRIES];
    logic [ple_pkg::ENTRIES-1:0] eq;

    // cells and their shift selects
    for (genvar g = 0; g < ple_pkg::ENTRIES; g++)
    begin : g_cell
        ple_pkg::cell_ctl_t cctl;
        logic signed [31:0] left_v;
        logic signed [31:0] right_v;

        always_comb
        begin
            cctl.load_new   = ctl.ins && (ple_pkg::IDX_W'(g) == ctl.pos);
            cctl.take_left  = ctl.ins && (ple_pkg::IDX_W'(g) >  ctl.pos);
            cctl.take_right = ctl.del && (ple_pkg::IDX_W'(g) >= ctl.pos);
        end

        if (g == 0)
        begin : g_first
            assign left_v = new_value;
        end
        else
        begin : g_inner_l
            assign left_v = vals[g-1];
        end

        if (g == ple_pkg::ENTRIES - 1)
        begin : g_last
            assign right_v = vals[g];
        end
        else
        begin : g_inner_r
            assign right_v = vals[g+1];
        end

        ple_cell u_cell (
            .clk         (clk),
            .ctl         (cctl),
            .new_value   (new_value),
            .left_value  (left_v),
            .right_value (right_v),
            .key         (new_value),
            .value       (vals[g]),
            .match       (eq[g])
        );
    end

    // indexed read
    assign rd_value = vals[ctl.pos];

    // lowest occupied matching entry
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = ple_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (eq[i] && (ple_pkg::CNT_W'(i) < count))
            begin
                hit     = 1'b1;
                hit_idx = ple_pkg::IDX_W'(i);
            end
        end
    end

endmodule

[tb/tb_positional_list_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Self-checking bench for the positional list engine. A short directed table
// covers the empty list, the full list, bad indexes, unknown request codes
// and clears at both ends of the count. A random run follows, weighted to
// fill and drain the list and to search for values it holds. Every response
// word is compared field by field with a shadow copy of the list (pinned rows
// with a typed-in word). Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;

    // request codes the block does not know
    localparam logic [2:0] REQ_BAD_LO = 3'd5;
    localparam logic [2:0] REQ_BAD_HI = 3'd7;

    localparam int RAND_PER_PHASE = 412;
    localparam int PHASES         = 4;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        ple_pkg::req_t     word;
        logic              pinned;
        ple_pkg::rsp_t     want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    ple_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    ple_pkg::rsp_t rsp;

    // sender side tag for rows whose response is typed in
    logic          req_pinned = 1'b0;
    ple_pkg::rsp_t req_want   = '0;

    int   gap_pct   = 0;
    int   stall_pct = 0;
    int   errors    = 0;
    int   n_req     = 0;
    int   n_rsp     = 0;
    int   st_seen [4];

    // shadow copy of the list
    logic signed [31:0] shadow_vals [ple_pkg::ENTRIES];
    int                 shadow_len = 0;

    ple_pkg::rsp_t replies_due [$];
    dir_row_t      script_rows [$];

    positional_list_engine_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // receiver stalls at random
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    // apply one request to the shadow list and return the response word
    function automatic ple_pkg::rsp_t list_apply(input ple_pkg::req_t w);
        ple_pkg::rsp_t r;
        int   i;
        int   p;
        logic hit;
        r   = '0;
        p   = int'(w.position);
        hit = 1'b0;
        case (w.req_type)
            ple_pkg::REQ_INSERT:
            begin
                if (shadow_len >= ple_pkg::ENTRIES)
                    r.status = ple_pkg::ST_FULL;
                else if (p > shadow_len)
                    r.status = ple_pkg::ST_MISS;
                else
                begin
                    for (i = shadow_len; i > p; i--)
                        shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[p] = w.data_value;
                    shadow_len++;
                end
            end
            ple_pkg::REQ_DELETE:
            begin
                if (p >= shadow_len)
                    r.status = ple_pkg::ST_MISS;
                else
                begin
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
            end
            ple_pkg::REQ_READ:
            begin
                if (p >= shadow_len)
                    r.status = ple_pkg::ST_MISS;
                else
                    r.read_value = shadow_vals[p];
            end
            ple_pkg::REQ_FIND:
            begin
                r.status = ple_pkg::ST_MISS;
                for (i = 0; i < shadow_len; i++)
                begin
                    if (!hit && shadow_vals[i] == w.data_value)
                    begin
                        hit           = 1'b1;
                        r.status      = ple_pkg::ST_OK;
                        r.found_index = ple_pkg::FLD_W'(i);
                    end
                end
            end
            ple_pkg::REQ_CLEAR:
            begin
                r.found_index = ple_pkg::FLD_W'(shadow_len);
                shadow_len    = 0;
            end
            default:
                r.status = ple_pkg::ST_MISS;
        endcase
        r.entry_count = ple_pkg::FLD_W'(shadow_len);
        return r;
    endfunction

    // one directed row; want fields only matter when pinned
    function automatic dir_row_t row(input logic [2:0] kind, input int pos,
                                     input logic signed [31:0] val, input int pin,
                                     input logic [1:0] st, input logic signed [31:0] rv,
                                     input int fi, input int cnt);
        dir_row_t d;
        d.word.req_type    = kind;
        d.word.position    = ple_pkg::FLD_W'(pos);
        d.word.data_value  = val;
        d.pinned           = (pin != 0);
        d.want.status      = st;
        d.want.read_value  = rv;
        d.want.found_index = ple_pkg::FLD_W'(fi);
        d.want.entry_count = ple_pkg::FLD_W'(cnt);
        return d;
    endfunction

    // random request, weighted toward legal indexes and values in the list
    function automatic ple_pkg::req_t make_random_request();
        ple_pkg::req_t w;
        int   pick;
        pick         = $urandom_range(99);
        w.data_value = ($urandom_range(1)) ? $urandom : $signed($urandom_range(8)) - 4;
        w.position   = ple_pkg::FLD_W'($urandom_range(31));
        if (pick < 36)
        begin
            w.req_type = ple_pkg::REQ_INSERT;
            if ($urandom_range(99) < 85)
                w.position = ple_pkg::FLD_W'($urandom_range(shadow_len));
        end
        else if (pick < 56)
        begin
            w.req_type = ple_pkg::REQ_DELETE;
            if (shadow_len > 0 && $urandom_range(99) < 85)
                w.position = ple_pkg::FLD_W'($urandom_range(shadow_len - 1));
        end
        else if (pick < 73)
        begin
            w.req_type = ple_pkg::REQ_READ;
            if (shadow_len > 0 && $urandom_range(99) < 85)
                w.position = ple_pkg::FLD_W'($urandom_range(shadow_len - 1));
        end
        else if (pick < 90)
        begin
            w.req_type = ple_pkg::REQ_FIND;
            if (shadow_len > 0 && $urandom_range(99) < 60)
                w.data_value = shadow_vals[$urandom_range(shadow_len - 1)];
        end
        else if (pick < 94)
            w.req_type = ple_pkg::REQ_CLEAR;
        else
            w.req_type = 3'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
        return w;
    endfunction

    // present one request word, called just after a falling edge
    task automatic push_request(input ple_pkg::req_t w, input logic pin,
                                input ple_pkg::rsp_t want);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req        <= w;
        req_pinned  = pin;
        req_want    = want;
        req_valid  <= 1'b1;
        @(posedge clk);
        while (!(req_valid && !req_stall))
            @(posedge clk);
        @(negedge clk);
    endtask

    // predict on accepted requests, check accepted responses
    always @(posedge clk)
    begin : watch_ports
        ple_pkg::rsp_t want;
        ple_pkg::rsp_t got;
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                want = list_apply(req);
                if (req_pinned)
                    want = req_want;
                replies_due.push_back(want);
                n_req++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                got = rsp;
                n_rsp++;
                st_seen[got.status]++;
                if (replies_due.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.read_value !== want.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, got.read_value);
                        errors++;
                    end
                    if (got.found_index !== want.found_index)
                    begin
                        $error("found_index: expected %0d, got %0d",
                               want.found_index, got.found_index);
                        errors++;
                    end
                    if (got.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, got.entry_count);
                        errors++;
                    end
                end
            end
        end
    end

    // hard limit on run length
    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        logic signed [31:0] fill_vals [16];
        int                 ph_gap   [PHASES];
        int                 ph_stall [PHASES];
        int                 k;
        int                 ph;
        int                 n;
        int                 pos;

        fill_vals = '{32'sh7fffffff, 32'sh80000000, -1, 0, 1, 42, 32'sh55555555,
                      32'shaaaaaaaa, 42, -2, 100, -100, 32'sh0000ffff, 32'shffff0000,
                      42, 7};
        ph_gap    = '{0, 83, 0, 7};
        ph_stall  = '{0, 0, 83, 7};
        st_seen   = '{0, 0, 0, 0};

        // empty list: every lookup misses, clear removes nothing
        script_rows.push_back(row(ple_pkg::REQ_READ,   0,  0, 1, ple_pkg::ST_MISS, 0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_DELETE, 0,  0, 1, ple_pkg::ST_MISS, 0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_FIND,   0,  0, 1, ple_pkg::ST_MISS, 0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_CLEAR,  0,  0, 1, ple_pkg::ST_OK,   0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_INSERT, 1,  9, 1, ple_pkg::ST_MISS, 0, 0, 0));
        script_rows.push_back(row(REQ_BAD_LO, 0, -1, 1, ple_pkg::ST_MISS, 0, 0, 0));
        script_rows.push_back(row(REQ_BAD_HI, 31, 32'sh7fffffff, 1, ple_pkg::ST_MISS,
                                  0, 0, 0));

        // fill to capacity at front, back and middle
        for (k = 0; k < ple_pkg::ENTRIES; k++)
        begin
            pos = (k % 3 == 0) ? 0 : (k % 3 == 1) ? k : k / 2;
            script_rows.push_back(row(ple_pkg::REQ_INSERT, pos, fill_vals[k], 1,
                                      ple_pkg::ST_OK, 0, 0, k + 1));
        end

        // full list: full flag wins over a bad index, then lookups and a full clear
        script_rows.push_back(row(ple_pkg::REQ_INSERT, 17, 3, 1, ple_pkg::ST_FULL, 0, 0,
                                  ple_pkg::ENTRIES));
        script_rows.push_back(row(ple_pkg::REQ_READ,   15, 0, 0, ple_pkg::ST_OK, 0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_READ,   0,  0, 0, ple_pkg::ST_OK, 0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_FIND,   0, 42, 0, ple_pkg::ST_OK, 0, 0, 0));
        script_rows.push_back(row(ple_pkg::REQ_DELETE, 16, 0, 1, ple_pkg::ST_MISS, 0, 0,
                                  ple_pkg::ENTRIES));
        script_rows.push_back(row(ple_pkg::REQ_CLEAR,  0,  0, 1, ple_pkg::ST_OK, 0,
                                  ple_pkg::ENTRIES, 0));

        // reset once
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table with light idling
        gap_pct   = 20;
        stall_pct = 20;
        for (k = 0; k < script_rows.size(); k++)
            push_request(script_rows[k].word, script_rows[k].pinned, script_rows[k].want);

        // random phases, each with its own idling mix
        for (ph = 0; ph < PHASES; ph++)
        begin
            gap_pct   = ph_gap[ph];
            stall_pct = ph_stall[ph];
            for (n = 0; n < RAND_PER_PHASE; n++)
                push_request(make_random_request(), 1'b0, '0);
        end

        // drain
        req_valid <= 1'b0;
        stall_pct  = 0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests sent: %0d, responses checked: %0d", n_req, n_rsp);
        $display("responses by status: ok %0d, miss %0d, full %0d",
                 st_seen[ple_pkg::ST_OK], st_seen[ple_pkg::ST_MISS],
                 st_seen[ple_pkg::ST_FULL]);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
